// ===== design/name_to_key_binding_table_core_assert.svh =====
// ----------------------------------------------------------------------------
// name_to_key_binding_table_core_assert.svh
// Assertion macros for the name-to-key binding table. They assume clk and
// arst_n in the scope where they are used.
// ----------------------------------------------------------------------------
`ifndef NAME_TO_KEY_BINDING_TABLE_CORE_ASSERT_SVH
`define NAME_TO_KEY_BINDING_TABLE_CORE_ASSERT_SVH

// antecedent holds -> consequent in the same cycle
`define N2K_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent holds -> consequent in the next cycle
`define N2K_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/n2k_pkg.sv =====
// ----------------------------------------------------------------------------
// n2k_pkg
// Shared constants, opcodes and a helper of the name-to-key binding table.
// ----------------------------------------------------------------------------
package n2k_pkg;

	localparam int NAME_BYTES_DEF  = 8;
	localparam int ENTRY_COUNT_DEF = 16;

	localparam int NAME_CHARS_W = 56;
	localparam int NAME_LEN_W   = 4;
	localparam int KEY_W        = 8;
	localparam int OPCODE_W     = 2;

	localparam int S_TDATA_W = 72;
	localparam int M_TDATA_W = 16;

	localparam logic [OPCODE_W-1:0] OP_NOTE   = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_LOOKUP = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_CLEAR  = 2'd2;

	// byte mask keeping the first len characters
	function automatic logic [NAME_CHARS_W-1:0] prefix_mask(input logic [NAME_LEN_W-1:0] len);
		logic [NAME_CHARS_W-1:0] m;
		m = '0;
		for (int b = 0; b < NAME_CHARS_W / 8; b++) begin
			m[b*8 +: 8] = (NAME_LEN_W'(b) < len) ? 8'hFF : 8'h00;
		end
		return m;
	endfunction

endpackage

// ===== design/n2k_ram.sv =====
// ----------------------------------------------------------------------------
// n2k_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module n2k_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== design/name_to_key_binding_table_core.sv =====
// ----------------------------------------------------------------------------
// name_to_key_binding_table_core
// Associative table binding short byte-string names to key codes, with
// round-robin replacement of the oldest slot.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream s_*: one transaction per operation. s_tuser carries the
//   opcode (note, lookup, clear). Master stream m_*: exactly one result
//   transaction per accepted operation, in order.
//   Note and lookup walk the entry RAM one slot per cycle through its single
//   read port; the scan ends at the first match or after the last slot, and a
//   note then writes its entry back before the result is registered. Clear,
//   unused opcodes and rejected ops go straight to the result register.
//   One operation is in flight at a time; s_tready is high only while the
//   engine is idle, from the cycle after each result is registered.
//   The result sits in an output register; a stalled receiver holds it and
//   the next operation may be accepted and worked on meanwhile, only its
//   own result waits for the register to drain.
//   Reset (arst_n low) empties the table at once via per-slot valid flops
//   and returns the replacement pointer to slot 0; clear does the same.
// ----------------------------------------------------------------------------
module name_to_key_binding_table_core #(
	parameter int NAME_BYTES  = n2k_pkg::NAME_BYTES_DEF,
	parameter int ENTRY_COUNT = n2k_pkg::ENTRY_COUNT_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// name_chars[55:0], name_len[59:56], key_code[67:60],
	// wide_char_present[68], zero pad[71:69]
	input  logic [n2k_pkg::S_TDATA_W-1:0]  s_tdata,
	// opcode[1:0]
	input  logic [n2k_pkg::OPCODE_W-1:0]   s_tuser,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// found_key[7:0], hit[8], accepted[9], zero pad[15:10]
	output logic [n2k_pkg::M_TDATA_W-1:0]  m_tdata,
	output logic                           m_tvalid,
	input  logic                           m_tready
);
	import n2k_pkg::*;

	localparam int NW = (NAME_BYTES - 1) * 8;
	localparam int LW = $clog2(NAME_BYTES);
	localparam int EW = LW + KEY_W + NW;
	localparam int AW = $clog2(ENTRY_COUNT);
	localparam int CW = AW + 1;
	localparam logic [NAME_LEN_W-1:0] NB_LEN = NAME_LEN_W'(NAME_BYTES);
	localparam logic [AW-1:0] LAST_SLOT = AW'(ENTRY_COUNT - 1);
	localparam logic [CW-1:0] SCAN_END  = CW'(ENTRY_COUNT);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_WRITE = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0] state_q;

	// input fields
	logic [NAME_CHARS_W-1:0] in_chars;
	logic [NAME_LEN_W-1:0]   in_len;
	logic [KEY_W-1:0]        in_key;
	logic                    in_wide;
	logic [OPCODE_W-1:0]     in_op;
	logic [NAME_CHARS_W-1:0] in_name_full;

	assign in_chars     = s_tdata[55:0];
	assign in_len       = s_tdata[59:56];
	assign in_key       = s_tdata[67:60];
	assign in_wide      = s_tdata[68];
	assign in_op        = s_tuser;
	assign in_name_full = in_chars & prefix_mask(in_len);

	logic len_ok, note_ok, look_ok, in_acc;
	assign len_ok  = (in_len != '0) && (in_len < NB_LEN);
	assign note_ok = (in_op == OP_NOTE) && len_ok && (in_key != '0);
	assign look_ok = (in_op == OP_LOOKUP) && len_ok && !in_wide;
	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;

	// operation registers
	logic                 is_note_q;
	logic [NW-1:0]        q_name_q;
	logic [LW-1:0]        q_len_q;
	logic [KEY_W-1:0]     key_q;

	// table control
	logic [ENTRY_COUNT-1:0] valid_q;
	logic [AW-1:0]          next_slot_q;
	logic [CW-1:0]          scan_q;
	logic [AW-1:0]          idx_s1;
	logic                   pend_s1;
	logic [AW-1:0]          slot_q;
	logic                   found_q;

	// result
	logic [KEY_W-1:0] res_key_q;
	logic             res_hit_q;
	logic             res_acc_q;
	logic             m_valid_q;
	logic [M_TDATA_W-1:0] m_data_q;

	// RAM
	logic          rd_en, wr_en;
	logic [AW-1:0] wr_addr;
	logic [EW-1:0] wr_data, rd_data;
	logic [NW-1:0] rd_name;
	logic [KEY_W-1:0] rd_key;
	logic [LW-1:0] rd_len;

	assign rd_en   = (state_q == ST_SCAN) && (scan_q < SCAN_END);
	assign wr_en   = (state_q == ST_WRITE);
	assign wr_addr = slot_q;
	assign wr_data = {q_len_q, key_q, q_name_q};
	assign rd_name = rd_data[NW-1:0];
	assign rd_key  = rd_data[NW +: KEY_W];
	assign rd_len  = rd_data[EW-1 -: LW];

	n2k_ram #(
		.WIDTH (EW),
		.DEPTH (ENTRY_COUNT)
	) u_entry_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (scan_q[AW-1:0]),
		.rd_data (rd_data)
	);

	logic match, scan_last, out_free;
	assign match     = pend_s1 && valid_q[idx_s1] && (rd_len == q_len_q) && (rd_name == q_name_q);
	assign scan_last = pend_s1 && (idx_s1 == LAST_SLOT);
	assign out_free  = !m_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			valid_q     <= '0;
			next_slot_q <= '0;
			scan_q      <= '0;
			pend_s1     <= 1'b0;
			m_valid_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						scan_q  <= '0;
						pend_s1 <= 1'b0;
						if (note_ok || look_ok) begin
							state_q <= ST_SCAN;
						end else begin
							if (in_op == OP_CLEAR) begin
								valid_q     <= '0;
								next_slot_q <= '0;
							end
							state_q <= ST_DONE;
						end
					end
				end
				ST_SCAN: begin
					pend_s1 <= rd_en;
					if (rd_en) begin
						scan_q <= scan_q + 1'b1;
					end
					if (match || scan_last) begin
						state_q <= is_note_q ? ST_WRITE : ST_DONE;
					end
				end
				ST_WRITE: begin
					valid_q[slot_q] <= 1'b1;
					if (!found_q) begin
						next_slot_q <= (next_slot_q == LAST_SLOT) ? '0 : next_slot_q + 1'b1;
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (state_q == ST_DONE && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			is_note_q <= note_ok;
			q_name_q  <= in_name_full[NW-1:0];
			q_len_q   <= in_len[LW-1:0];
			key_q     <= in_key;
			res_key_q <= '0;
			res_hit_q <= 1'b0;
			res_acc_q <= 1'b0;
		end
		if (rd_en) begin
			idx_s1 <= scan_q[AW-1:0];
		end
		if (state_q == ST_SCAN && (match || scan_last)) begin
			found_q   <= match;
			slot_q    <= match ? idx_s1 : next_slot_q;
			res_key_q <= (match && !is_note_q) ? rd_key : '0;
			res_hit_q <= match && !is_note_q;
		end
		if (state_q == ST_WRITE) begin
			res_acc_q <= 1'b1;
		end
		if (state_q == ST_DONE && out_free) begin
			m_data_q <= {{(M_TDATA_W - KEY_W - 2){1'b0}}, res_acc_q, res_hit_q, res_key_q};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	`include "name_to_key_binding_table_core_assert.svh"

	`N2K_ASSERT_NOW(a_miss_key_zero, m_tvalid && !m_tdata[KEY_W], m_tdata[KEY_W-1:0] == '0, "key on a miss")
	`N2K_ASSERT_NOW(a_hit_not_acc, m_tvalid, !(m_tdata[KEY_W] && m_tdata[KEY_W+1]), "hit and accepted together")
	`N2K_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready, "second transaction taken while busy")
	`N2K_ASSERT_NOW(a_slot_range, 1'b1, next_slot_q <= LAST_SLOT, "replacement pointer out of range")

endmodule
